FILE: src/bls_pkg.sv
package bls_pkg;

  // Coordinate width of every endpoint and pixel position.
  localparam int CoordBits = 16;
  localparam int ColorBits = 32;
  localparam int FrameBits = 13;

  // Absolute distances need one more bit, the error term two more.
  localparam int DeltaBits = CoordBits + 1;
  localparam int ErrBits   = CoordBits + 2;

  localparam int InDataRaw  = 4 * CoordBits + ColorBits;
  localparam int InDataBits = ((InDataRaw + 7) / 8) * 8;
  localparam int OutDataRaw  = 2 * CoordBits + ColorBits;
  localparam int OutDataBits = ((OutDataRaw + 7) / 8) * 8;

  localparam logic [FrameBits-1:0] FrameWidthReset  = FrameBits'(640);
  localparam logic [FrameBits-1:0] FrameHeightReset = FrameBits'(480);

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [DeltaBits-1:0]        delta_t;
  typedef logic signed [ErrBits-1:0]   err_t;
  typedef logic [ColorBits-1:0]        color_t;
  typedef logic [FrameBits-1:0]        frame_t;

  typedef enum logic {
    CmdStart = 1'b0,
    CmdNext  = 1'b1
  } cmd_e;

  typedef enum logic {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } reg_e;

endpackage

FILE: src/bresenham_line_stepper.sv
// A pixel is in the output register in the cycle after its command transfer.
// Throughput: one command per cycle while the output register is empty or its held pixel
// is taken in the same cycle; otherwise s_axis_tready_o is low and the command stalls.
// Reset (rst_ni low, asynchronous): no line active, output empty, walk state zero,
// frame size back to 640 x 480.
module bresenham_line_stepper (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [bls_pkg::FrameBits-1:0]     cfg_data_i,
  // Command stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: x_start, y_start, x_end, y_end, color (from bit 0 up)
  input  logic [bls_pkg::InDataBits-1:0]    s_axis_tdata_i,
  // tuser: cmd
  input  logic                              s_axis_tuser_i,
  // Pixel stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: out_x, out_y, out_color (from bit 0 up)
  output logic [bls_pkg::OutDataBits-1:0]   m_axis_tdata_o,
  // tuser: on_screen
  output logic                              m_axis_tuser_o,
  // tlast: last_pixel
  output logic                              m_axis_tlast_o
);

  localparam int Cb = bls_pkg::CoordBits;
  localparam int CmpBits = bls_pkg::CoordBits + bls_pkg::FrameBits;

  // Frame size registers
  bls_pkg::frame_t frame_w_q, frame_h_q;

  // Walk state
  bls_pkg::coord_t cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
  bls_pkg::delta_t dx_q, dy_q;
  logic            neg_x_q, neg_y_q;
  bls_pkg::err_t   err_q;
  bls_pkg::color_t color_q;
  logic            busy_q;

  // Output register
  logic            out_valid_q;
  bls_pkg::coord_t out_x_q, out_y_q;
  bls_pkg::color_t out_color_q;
  logic            out_on_q, out_last_q;

  // ---------------------------------------------------------------------------
  // Handshake: take a command whenever the output register is empty or drains
  // ---------------------------------------------------------------------------
  logic          in_xfer, do_start, do_next, produce;
  bls_pkg::cmd_e cmd;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd      = bls_pkg::cmd_e'(s_axis_tuser_i);
  assign do_start = in_xfer && (cmd == bls_pkg::CmdStart);
  // A next command with no line running is dropped without a result.
  assign do_next  = in_xfer && (cmd == bls_pkg::CmdNext) && busy_q;
  assign produce  = do_start || do_next;

  // ---------------------------------------------------------------------------
  // Start path: set up endpoints, distances, directions and the error term
  // ---------------------------------------------------------------------------
  bls_pkg::coord_t x0, y0, x1, y1;
  bls_pkg::coord_t xa, xb, ya, yb;
  logic            swap_y, swap_x;
  logic signed [Cb:0] dxs, dys;
  bls_pkg::delta_t st_dx, st_dy;
  bls_pkg::err_t   st_err;
  logic            st_neg_x, st_neg_y;

  assign x0 = s_axis_tdata_i[0*Cb +: Cb];
  assign y0 = s_axis_tdata_i[1*Cb +: Cb];
  assign x1 = s_axis_tdata_i[2*Cb +: Cb];
  assign y1 = s_axis_tdata_i[3*Cb +: Cb];

  always_comb begin
    // A vertical line (or a point) walks from its smaller y upward.
    swap_y = (x0 == x1) && (y0 > y1);
    ya     = swap_y ? y1 : y0;
    yb     = swap_y ? y0 : y1;
    // A horizontal line walks from its smaller x upward.
    swap_x = (ya == yb) && (x0 > x1);
    xa     = swap_x ? x1 : x0;
    xb     = swap_x ? x0 : x1;

    dxs = (Cb+1)'(xb) - (Cb+1)'(xa);
    dys = (Cb+1)'(yb) - (Cb+1)'(ya);
    st_dx = dxs[Cb] ? bls_pkg::DeltaBits'(-dxs) : bls_pkg::DeltaBits'(dxs);
    st_dy = dys[Cb] ? bls_pkg::DeltaBits'(-dys) : bls_pkg::DeltaBits'(dys);

    st_neg_x = !(xa < xb);
    st_neg_y = !(ya < yb);
    st_err   = $signed({1'b0, st_dx}) - $signed({1'b0, st_dy});
  end

  // ---------------------------------------------------------------------------
  // Step path: one Bresenham step, e2 = 2*err against -dy and dx
  // ---------------------------------------------------------------------------
  logic signed [bls_pkg::ErrBits:0] e2, neg_dy, pos_dx;
  logic            take_x, take_y;
  bls_pkg::err_t   nx_err;
  bls_pkg::coord_t nx_x, nx_y;

  always_comb begin
    e2     = {err_q, 1'b0};
    pos_dx = $signed({2'b00, dx_q});
    neg_dy = -$signed({2'b00, dy_q});
    take_x = e2 > neg_dy;
    take_y = e2 < pos_dx;

    nx_err = err_q;
    nx_x   = cur_x_q;
    nx_y   = cur_y_q;
    if (take_x) begin
      nx_err = nx_err - $signed({1'b0, dy_q});
      nx_x   = neg_x_q ? cur_x_q - Cb'(1) : cur_x_q + Cb'(1);
    end
    if (take_y) begin
      nx_err = nx_err + $signed({1'b0, dx_q});
      nx_y   = neg_y_q ? cur_y_q - Cb'(1) : cur_y_q + Cb'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel flags for whichever position is produced this cycle
  // ---------------------------------------------------------------------------
  bls_pkg::coord_t px_x, px_y, px_tx, px_ty;
  bls_pkg::color_t px_color;
  logic            px_on, px_last;

  always_comb begin
    px_x     = do_start ? xa : nx_x;
    px_y     = do_start ? ya : nx_y;
    px_tx    = do_start ? xb : tgt_x_q;
    px_ty    = do_start ? yb : tgt_y_q;
    px_color = do_start ? s_axis_tdata_i[4*Cb +: bls_pkg::ColorBits] : color_q;
    px_last  = (px_x == px_tx) && (px_y == px_ty);
    px_on    = !px_x[Cb-1] && !px_y[Cb-1]
               && (CmpBits'($unsigned(px_x)) < CmpBits'(frame_w_q))
               && (CmpBits'($unsigned(px_y)) < CmpBits'(frame_h_q));
  end

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q <= bls_pkg::FrameWidthReset;
      frame_h_q <= bls_pkg::FrameHeightReset;
    end else if (cfg_we_i) begin
      unique case (bls_pkg::reg_e'(cfg_index_i))
        bls_pkg::RegFrameWidth:  frame_w_q <= cfg_data_i;
        bls_pkg::RegFrameHeight: frame_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Walk state: load on start, advance on next
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      tgt_x_q <= '0;
      tgt_y_q <= '0;
      dx_q    <= '0;
      dy_q    <= '0;
      neg_x_q <= 1'b0;
      neg_y_q <= 1'b0;
      err_q   <= '0;
      color_q <= '0;
      busy_q  <= 1'b0;
    end else if (do_start) begin
      cur_x_q <= xa;
      cur_y_q <= ya;
      tgt_x_q <= xb;
      tgt_y_q <= yb;
      dx_q    <= st_dx;
      dy_q    <= st_dy;
      neg_x_q <= st_neg_x;
      neg_y_q <= st_neg_y;
      err_q   <= st_err;
      color_q <= px_color;
      busy_q  <= !px_last;
    end else if (do_next) begin
      cur_x_q <= nx_x;
      cur_y_q <= nx_y;
      err_q   <= nx_err;
      busy_q  <= !px_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold the pixel until its transfer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (produce) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      out_x_q     <= px_x;
      out_y_q     <= px_y;
      out_color_q <= px_color;
      out_on_q    <= px_on;
      out_last_q  <= px_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = bls_pkg::OutDataBits'({out_color_q, out_y_q, out_x_q});
  assign m_axis_tuser_o  = out_on_q;
  assign m_axis_tlast_o  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_start_gives_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && cmd == bls_pkg::CmdStart) |=> m_axis_tvalid_o)
    else $error("start transfer produced no pixel");

  a_idle_next_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && cmd == bls_pkg::CmdNext && !busy_q) |=> !m_axis_tvalid_o)
    else $error("next command while idle produced a pixel");

  a_busy_tracks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (busy_q == !m_axis_tlast_o))
    else $error("line activity disagrees with last-pixel flag");

  // A running line always has a pixel left, so every step moves x, y or both.
  a_next_moves_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_next |-> (take_x || take_y))
    else $error("next step moved neither coordinate");

endmodule
